[design/ebpf_instruction_executor_assert.svh]
// ----------------------------------------------------------------------------
// eBPF instruction executor assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EBPF_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define EBPF_INSTRUCTION_EXECUTOR_ASSERT_SVH

// The condition holds at every clock edge out of reset.
`define EIE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define EIE_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[design/eie_pkg.sv]
// ----------------------------------------------------------------------------
// eBPF instruction executor package
// Item types, sizes and opcode field codes shared by the executor modules.
// ----------------------------------------------------------------------------
package eie_pkg;

    localparam int STACK_BYTES    = 512;
    localparam int REGISTER_COUNT = 12;
    localparam int SAW            = $clog2(STACK_BYTES);
    localparam int RIW            = $clog2(REGISTER_COUNT);
    localparam int QUEUE_DEPTH    = 2;
    localparam int QAW            = $clog2(QUEUE_DEPTH);
    localparam int QCW            = $clog2(QUEUE_DEPTH + 1);
    localparam logic [RIW-1:0] FRAME_INDEX = RIW'(10);

    localparam logic [2:0] CLS_LD    = 3'd0;
    localparam logic [2:0] CLS_LDX   = 3'd1;
    localparam logic [2:0] CLS_ST    = 3'd2;
    localparam logic [2:0] CLS_STX   = 3'd3;
    localparam logic [2:0] CLS_ALU   = 3'd4;
    localparam logic [2:0] CLS_JMP   = 3'd5;
    localparam logic [2:0] CLS_JMP32 = 3'd6;
    localparam logic [2:0] CLS_ALU64 = 3'd7;

    localparam logic [3:0] ALU_ADD  = 4'h0;
    localparam logic [3:0] ALU_SUB  = 4'h1;
    localparam logic [3:0] ALU_MUL  = 4'h2;
    localparam logic [3:0] ALU_DIV  = 4'h3;
    localparam logic [3:0] ALU_OR   = 4'h4;
    localparam logic [3:0] ALU_AND  = 4'h5;
    localparam logic [3:0] ALU_LSH  = 4'h6;
    localparam logic [3:0] ALU_RSH  = 4'h7;
    localparam logic [3:0] ALU_NEG  = 4'h8;
    localparam logic [3:0] ALU_MOD  = 4'h9;
    localparam logic [3:0] ALU_XOR  = 4'hA;
    localparam logic [3:0] ALU_MOV  = 4'hB;
    localparam logic [3:0] ALU_ARSH = 4'hC;
    localparam logic [3:0] ALU_END  = 4'hD;

    localparam logic [3:0] JMP_JA     = 4'h0;
    localparam logic [3:0] JMP_JEQ    = 4'h1;
    localparam logic [3:0] JMP_JGT    = 4'h2;
    localparam logic [3:0] JMP_JGE    = 4'h3;
    localparam logic [3:0] JMP_JSET   = 4'h4;
    localparam logic [3:0] JMP_JNE    = 4'h5;
    localparam logic [3:0] JMP_JSGT   = 4'h6;
    localparam logic [3:0] JMP_JSGE   = 4'h7;
    localparam logic [3:0] JMP_HELPER = 4'h8;
    localparam logic [3:0] JMP_RETURN = 4'h9;
    localparam logic [3:0] JMP_JLT    = 4'hA;
    localparam logic [3:0] JMP_JLE    = 4'hB;
    localparam logic [3:0] JMP_JSLT   = 4'hC;
    localparam logic [3:0] JMP_JSLE   = 4'hD;

    localparam logic [2:0] MODE_MEM    = 3'd3;
    localparam logic [2:0] MODE_ATOMIC = 3'd6;
    localparam logic [7:0] OP_LDDW     = 8'h18;

    localparam logic [1:0] SIZE_W  = 2'd0;
    localparam logic [1:0] SIZE_H  = 2'd1;
    localparam logic [1:0] SIZE_B  = 2'd2;
    localparam logic [1:0] SIZE_DW = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_BADOP = 2'd1;
    localparam logic [1:0] STATUS_MEM   = 2'd2;

    typedef struct packed {
        logic [7:0]         opcode;
        logic [3:0]         dst_index;
        logic [3:0]         src_index;
        logic signed [15:0] offset;
        logic signed [31:0] immediate;
        logic [31:0]        immediate_next;
    } req_t;

    typedef struct packed {
        logic signed [16:0] pc_step;
        logic               exited;
        logic [63:0]        return_value;
        logic [1:0]         status;
    } rsp_t;

    typedef struct packed {
        req_t       req;
        logic [2:0] cls;
        logic [3:0] kind;
        logic       src_reg;
        logic       bad_index;
    } decoded_t;

endpackage

[design/ebpf_instruction_executor.sv]
// ALU, jump and wide-load path: queue, S_IDLE, S_EXEC, S_FIN, then the output register.
// The sequencer (pop, execute, retire) takes a new item only once the last has retired.
// Multiply reuses one 32x32 multiplier; divide and modulo run in the serial divider.
// Stack bytes go one at a time: S_MEM_RD and S_MEM_CAP per read, S_MEM_WR per write.
// After reset the stack is cleared byte by byte; no item is accepted during the clear.
// ----------------------------------------------------------------------------
// eBPF instruction executor
// Executes one eBPF instruction per item and reports step, exit, R0 and status.
// ----------------------------------------------------------------------------
module ebpf_instruction_executor import eie_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic     hold;
    logic     head_valid;
    decoded_t head;
    logic     pop;

    eie_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .hold       (hold),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    eie_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .hold       (hold),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule

[design/eie_front.sv]
// ----------------------------------------------------------------------------
// eBPF executor front end
// Accepts instructions, splits the opcode into its fields and queues them.
// ----------------------------------------------------------------------------
module eie_front import eie_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  req_t     req,
    input  logic     hold,
    output logic     head_valid,
    output decoded_t head,
    input  logic     pop
);

    decoded_t           q_reg [QUEUE_DEPTH];
    logic [QAW-1:0]     wr_ptr_reg;
    logic [QAW-1:0]     rd_ptr_reg;
    logic [QCW-1:0]     count_reg;
    logic [QCW-1:0]     count_next;
    decoded_t           dec;
    logic               push;
    logic               take;

    always_comb
    begin
        dec.req       = req;
        dec.cls       = req.opcode[2:0];
        dec.kind      = req.opcode[7:4];
        dec.src_reg   = req.opcode[3];
        dec.bad_index = (req.dst_index > 4'd10) || (req.src_index > 4'd10);
    end

    assign req_stall  = hold || (count_reg == QCW'(QUEUE_DEPTH));
    assign push       = req_valid && !req_stall;
    assign head_valid = (count_reg != '0);
    assign head       = q_reg[rd_ptr_reg];
    assign take       = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !take)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (take && !push)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (take)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

[design/eie_div.sv]
// ----------------------------------------------------------------------------
// eBPF executor divider
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eie_div import eie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic [63:0] remainder
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] n_reg;
    logic [64:0] r_reg;
    logic [63:0] d_reg;
    logic [64:0] r_shift;
    logic        ge;

    assign r_shift   = {r_reg[63:0], n_reg[63]};
    assign ge        = r_shift >= {1'b0, d_reg};
    assign done      = done_reg;
    assign quotient  = n_reg;
    assign remainder = r_reg[63:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= dividend;
            d_reg <= divisor;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[62:0], ge};
            r_reg <= ge ? (r_shift - {1'b0, d_reg}) : r_shift;
        end
    end

endmodule

[design/eie_stack.sv]
// ----------------------------------------------------------------------------
// eBPF executor stack memory
// Byte-wide local stack with one write port and one registered read port.
// ----------------------------------------------------------------------------
module eie_stack import eie_pkg::*;
(
    input  logic           clk,
    input  logic           we,
    input  logic [SAW-1:0] waddr,
    input  logic [7:0]     wdata,
    input  logic [SAW-1:0] raddr,
    output logic [7:0]     rdata
);

    logic [7:0] mem_reg [STACK_BYTES];
    logic [7:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

endmodule

[design/eie_back.sv]
// ----------------------------------------------------------------------------
// eBPF executor back end
// Executes queued instructions against the register file and the stack.
// ----------------------------------------------------------------------------
module eie_back import eie_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     head_valid,
    input  decoded_t head,
    output logic     pop,
    output logic     hold,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output rsp_t     rsp
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_MEM_RD,
        S_MEM_CAP,
        S_MEM_WR,
        S_FIN
    } state_t;

    state_t             state_reg;
    decoded_t           ins_reg;
    logic [63:0]        rf_reg [REGISTER_COUNT];
    logic [63:0]        opa_reg;
    logic [63:0]        opb_reg;
    logic [63:0]        opx_reg;
    logic [63:0]        opy_reg;
    logic               wb_en_reg;
    logic [63:0]        wb_val_reg;
    logic signed [16:0] step_reg;
    logic               exited_reg;
    logic [1:0]         status_reg;
    logic [SAW-1:0]     clr_cnt_reg;
    logic [SAW-1:0]     mem_addr_reg;
    logic [3:0]         mem_cnt_reg;
    logic [3:0]         mem_size_reg;
    logic [63:0]        mem_data_reg;
    logic [1:0]         mul_cnt_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        acc_reg;
    logic               out_valid_reg;
    rsp_t               out_reg;

    logic [63:0]        imm64;
    logic [63:0]        off64;
    logic               wide;
    logic [63:0]        mask;
    logic [63:0]        sign;
    logic [63:0]        av;
    logic [63:0]        bv;
    logic [5:0]         sh;
    logic [63:0]        alu_r;
    logic [63:0]        end_r;
    logic [63:0]        sa;
    logic [63:0]        sb;
    logic               cmp_ok;
    logic               cmp_taken;
    logic [3:0]         mem_size;
    logic               xadd;
    logic [63:0]        mem_base;
    logic [63:0]        mem_addr;
    logic [SAW:0]       mem_end;
    logic               in_window;
    logic signed [16:0] jump_step;

    state_t             ex_state;
    logic               ex_wb_en;
    logic [63:0]        ex_wb_val;
    logic signed [16:0] ex_step;
    logic               ex_exited;
    logic [1:0]         ex_status;
    logic [63:0]        ex_store;
    logic               ex_div;

    logic               div_done;
    logic [63:0]        div_q;
    logic [63:0]        div_r;
    logic [31:0]        mul_x;
    logic [31:0]        mul_y;
    logic [63:0]        acc_sum;
    logic [SAW-1:0]     byte_addr;
    logic               st_we;
    logic [SAW-1:0]     st_waddr;
    logic [7:0]         st_wdata;
    logic [7:0]         st_rdata;
    logic [63:0]        cap_data;
    logic               mem_last;
    logic               slot_free;
    logic [63:0]        r0_after;

    function automatic logic [63:0] swap16(input logic [63:0] v);
        swap16 = {48'b0, v[7:0], v[15:8]};
    endfunction

    function automatic logic [63:0] swap32(input logic [63:0] v);
        swap32 = {32'b0, v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [63:0] swap64(input logic [63:0] v);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            r[8*i +: 8] = v[8*(7-i) +: 8];
        end
        swap64 = r;
    endfunction

    eie_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ex_div && (state_reg == S_EXEC)),
        .dividend  (av),
        .divisor   (bv),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    eie_stack u_stack (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (byte_addr),
        .rdata (st_rdata)
    );

    assign hold      = (state_reg == S_CLEAR);
    assign pop       = (state_reg == S_IDLE) && head_valid;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign slot_free = !out_valid_reg || !rsp_stall;
    assign byte_addr = mem_addr_reg + SAW'(mem_cnt_reg);
    assign mem_last  = (mem_cnt_reg + 4'd1) == mem_size_reg;
    assign cap_data  = mem_data_reg | ({56'b0, st_rdata} << {mem_cnt_reg, 3'b000});
    assign r0_after  = (wb_en_reg && ins_reg.req.dst_index == 4'd0) ? wb_val_reg : rf_reg[0];

    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = byte_addr;
        st_wdata = mem_data_reg[7:0];
        if (state_reg == S_CLEAR)
        begin
            st_we    = 1'b1;
            st_waddr = clr_cnt_reg;
            st_wdata = 8'h00;
        end
        else if (state_reg == S_MEM_WR)
        begin
            st_we = 1'b1;
        end
    end

    always_comb
    begin
        mul_x   = opx_reg[31:0];
        mul_y   = opy_reg[31:0];
        acc_sum = acc_reg + {prod_reg[31:0], 32'b0};
        case (mul_cnt_reg)
            2'd1:
            begin
                mul_y   = opy_reg[63:32];
                acc_sum = prod_reg;
            end
            2'd2:
            begin
                mul_x = opx_reg[63:32];
            end
            default:
            begin
                mul_x = opx_reg[31:0];
            end
        endcase
    end

    always_comb
    begin
        imm64 = {{32{ins_reg.req.immediate[31]}}, ins_reg.req.immediate};
        off64 = {{48{ins_reg.req.offset[15]}}, ins_reg.req.offset};
        wide  = (ins_reg.cls == CLS_ALU64) || (ins_reg.cls == CLS_JMP);
        mask  = wide ? {64{1'b1}} : {32'b0, {32{1'b1}}};
        sign  = wide ? {1'b1, 63'b0} : {32'b0, 1'b1, 31'b0};
        av    = opa_reg & mask;
        bv    = (ins_reg.src_reg ? opb_reg : imm64) & mask;
        sh    = wide ? bv[5:0] : {1'b0, bv[4:0]};
        sa    = av ^ sign;
        sb    = bv ^ sign;

        case (ins_reg.kind)
            ALU_ADD:  alu_r = av + bv;
            ALU_SUB:  alu_r = av - bv;
            ALU_OR:   alu_r = av | bv;
            ALU_AND:  alu_r = av & bv;
            ALU_LSH:  alu_r = av << sh;
            ALU_RSH:  alu_r = av >> sh;
            ALU_NEG:  alu_r = 64'd0 - av;
            ALU_XOR:  alu_r = av ^ bv;
            ALU_MOV:  alu_r = bv;
            ALU_ARSH:
            begin
                if (wide)
                begin
                    alu_r = 64'($signed(av) >>> sh);
                end
                else
                begin
                    alu_r = {32'b0, 32'($signed(av[31:0]) >>> sh[4:0])};
                end
            end
            default:  alu_r = av;
        endcase

        end_r = opa_reg;
        if (imm64 == 64'd16)
        begin
            end_r = ins_reg.src_reg ? swap16(opa_reg) : {48'b0, opa_reg[15:0]};
        end
        else if (imm64 == 64'd32)
        begin
            end_r = ins_reg.src_reg ? swap32(opa_reg) : {32'b0, opa_reg[31:0]};
        end
        else if (imm64 == 64'd64)
        begin
            end_r = ins_reg.src_reg ? swap64(opa_reg) : opa_reg;
        end

        cmp_ok = 1'b1;
        case (ins_reg.kind)
            JMP_JEQ:  cmp_taken = av == bv;
            JMP_JGT:  cmp_taken = av > bv;
            JMP_JGE:  cmp_taken = av >= bv;
            JMP_JSET: cmp_taken = (av & bv) != 64'd0;
            JMP_JNE:  cmp_taken = av != bv;
            JMP_JSGT: cmp_taken = sa > sb;
            JMP_JSGE: cmp_taken = sa >= sb;
            JMP_JLT:  cmp_taken = av < bv;
            JMP_JLE:  cmp_taken = av <= bv;
            JMP_JSLT: cmp_taken = sa < sb;
            JMP_JSLE: cmp_taken = sa <= sb;
            default:
            begin
                cmp_ok    = 1'b0;
                cmp_taken = 1'b0;
            end
        endcase

        case (ins_reg.req.opcode[4:3])
            SIZE_W:  mem_size = 4'd4;
            SIZE_H:  mem_size = 4'd2;
            SIZE_B:  mem_size = 4'd1;
            default: mem_size = 4'd8;
        endcase
        xadd = (ins_reg.cls == CLS_STX) && (ins_reg.req.opcode[7:5] == MODE_ATOMIC)
            && (ins_reg.req.opcode[4:3] == SIZE_W || ins_reg.req.opcode[4:3] == SIZE_DW);
        mem_base  = (ins_reg.cls == CLS_LDX) ? opb_reg : opa_reg;
        mem_addr  = mem_base + off64;
        mem_end   = {1'b0, mem_addr[SAW-1:0]} + (SAW+1)'(mem_size);
        in_window = (mem_addr[63:SAW] == '0) && (mem_end <= (SAW+1)'(STACK_BYTES));
        jump_step = 17'sd1 + {ins_reg.req.offset[15], ins_reg.req.offset};
    end

    always_comb
    begin
        ex_state  = S_FIN;
        ex_wb_en  = 1'b0;
        ex_wb_val = alu_r & mask;
        ex_step   = 17'sd1;
        ex_exited = 1'b0;
        ex_status = STATUS_OK;
        ex_store  = (ins_reg.cls == CLS_ST) ? imm64 : opb_reg;
        ex_div    = 1'b0;
        if (ins_reg.bad_index)
        begin
            ex_status = STATUS_BADOP;
        end
        else
        begin
            case (ins_reg.cls)
                CLS_ALU, CLS_ALU64:
                begin
                    ex_wb_en = 1'b1;
                    case (ins_reg.kind)
                        ALU_MUL:
                        begin
                            ex_wb_en = 1'b0;
                            ex_state = S_MUL;
                        end
                        ALU_DIV, ALU_MOD:
                        begin
                            if (bv == 64'd0)
                            begin
                                ex_wb_val = (ins_reg.kind == ALU_DIV) ? 64'd0 : av;
                            end
                            else
                            begin
                                ex_wb_en = 1'b0;
                                ex_div   = 1'b1;
                                ex_state = S_DIV;
                            end
                        end
                        ALU_NEG:
                        begin
                            if (ins_reg.src_reg)
                            begin
                                ex_wb_en  = 1'b0;
                                ex_status = STATUS_BADOP;
                            end
                        end
                        ALU_END:
                        begin
                            if (wide)
                            begin
                                ex_wb_en  = 1'b0;
                                ex_status = STATUS_BADOP;
                            end
                            else
                            begin
                                ex_wb_val = end_r;
                            end
                        end
                        4'hE, 4'hF:
                        begin
                            ex_wb_en  = 1'b0;
                            ex_status = STATUS_BADOP;
                        end
                        default:
                        begin
                            ex_wb_val = alu_r & mask;
                        end
                    endcase
                end
                CLS_JMP, CLS_JMP32:
                begin
                    if (ins_reg.kind == JMP_JA || ins_reg.kind == JMP_HELPER
                        || ins_reg.kind == JMP_RETURN)
                    begin
                        if (ins_reg.cls != CLS_JMP || ins_reg.src_reg)
                        begin
                            ex_status = STATUS_BADOP;
                        end
                        else if (ins_reg.kind == JMP_JA)
                        begin
                            ex_step = jump_step;
                        end
                        else if (ins_reg.kind == JMP_RETURN)
                        begin
                            ex_exited = 1'b1;
                        end
                    end
                    else if (!cmp_ok)
                    begin
                        ex_status = STATUS_BADOP;
                    end
                    else if (cmp_taken)
                    begin
                        ex_step = jump_step;
                    end
                end
                CLS_LD:
                begin
                    if (ins_reg.req.opcode == OP_LDDW)
                    begin
                        ex_wb_en  = 1'b1;
                        ex_wb_val = {ins_reg.req.immediate_next, ins_reg.req.immediate};
                        ex_step   = 17'sd2;
                    end
                    else
                    begin
                        ex_status = STATUS_BADOP;
                    end
                end
                default:
                begin
                    if (ins_reg.req.opcode[7:5] != MODE_MEM && !xadd)
                    begin
                        ex_status = STATUS_BADOP;
                    end
                    else if (!in_window)
                    begin
                        ex_status = STATUS_MEM;
                    end
                    else if (ins_reg.cls == CLS_LDX || xadd)
                    begin
                        ex_state = S_MEM_RD;
                    end
                    else
                    begin
                        ex_state = S_MEM_WR;
                    end
                end
            endcase
        end
        if (ex_status != STATUS_OK || ex_exited)
        begin
            ex_step  = 17'sd0;
            ex_state = S_FIN;
            ex_div   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < REGISTER_COUNT; i++)
            begin
                rf_reg[i] <= '0;
            end
            rf_reg[FRAME_INDEX] <= 64'(STACK_BYTES);
        end
        else
        begin
            if (out_valid_reg && !rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + SAW'(1);
                    if (clr_cnt_reg == SAW'(STACK_BYTES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (head_valid)
                    begin
                        ins_reg   <= head;
                        opa_reg   <= head.bad_index ? 64'd0 : rf_reg[head.req.dst_index];
                        opb_reg   <= head.bad_index ? 64'd0 : rf_reg[head.req.src_index];
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    wb_en_reg    <= ex_wb_en;
                    wb_val_reg   <= ex_wb_val;
                    step_reg     <= ex_step;
                    exited_reg   <= ex_exited;
                    status_reg   <= ex_status;
                    opx_reg      <= av;
                    opy_reg      <= bv;
                    mul_cnt_reg  <= 2'd0;
                    acc_reg      <= '0;
                    mem_addr_reg <= mem_addr[SAW-1:0];
                    mem_size_reg <= mem_size;
                    mem_cnt_reg  <= 4'd0;
                    mem_data_reg <= (ex_state == S_MEM_WR) ? ex_store : 64'd0;
                    state_reg    <= ex_state;
                end
                S_MUL:
                begin
                    prod_reg    <= {32'b0, mul_x} * {32'b0, mul_y};
                    mul_cnt_reg <= mul_cnt_reg + 2'd1;
                    if (mul_cnt_reg != 2'd0)
                    begin
                        acc_reg <= acc_sum;
                    end
                    if (mul_cnt_reg == 2'd3)
                    begin
                        wb_en_reg  <= 1'b1;
                        wb_val_reg <= acc_sum & mask;
                        state_reg  <= S_FIN;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        wb_en_reg  <= 1'b1;
                        wb_val_reg <= (ins_reg.kind == ALU_DIV) ? div_q : div_r;
                        state_reg  <= S_FIN;
                    end
                end
                S_MEM_RD:
                begin
                    state_reg <= S_MEM_CAP;
                end
                S_MEM_CAP:
                begin
                    mem_data_reg <= cap_data;
                    mem_cnt_reg  <= mem_cnt_reg + 4'd1;
                    state_reg    <= S_MEM_RD;
                    if (mem_last)
                    begin
                        if (ins_reg.cls == CLS_LDX)
                        begin
                            wb_en_reg  <= 1'b1;
                            wb_val_reg <= cap_data;
                            state_reg  <= S_FIN;
                        end
                        else
                        begin
                            mem_data_reg <= cap_data + opb_reg;
                            mem_cnt_reg  <= 4'd0;
                            state_reg    <= S_MEM_WR;
                        end
                    end
                end
                S_MEM_WR:
                begin
                    mem_data_reg <= {8'b0, mem_data_reg[63:8]};
                    mem_cnt_reg  <= mem_cnt_reg + 4'd1;
                    if (mem_last)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (slot_free)
                    begin
                        if (wb_en_reg)
                        begin
                            rf_reg[ins_reg.req.dst_index] <= wb_val_reg;
                        end
                        out_valid_reg        <= 1'b1;
                        out_reg.pc_step      <= step_reg;
                        out_reg.exited       <= exited_reg;
                        out_reg.return_value <= r0_after;
                        out_reg.status       <= status_reg;
                        state_reg            <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `include "ebpf_instruction_executor_assert.svh"

    `EIE_ASSERT_IMPLY(a_fault_no_step, out_valid_reg && out_reg.status != STATUS_OK, out_reg.pc_step == 17'sd0 && !out_reg.exited, "faulting result moves the program counter")
    `EIE_ASSERT_IMPLY(a_mem_cnt_bound, state_reg == S_MEM_RD || state_reg == S_MEM_CAP || state_reg == S_MEM_WR, mem_cnt_reg < mem_size_reg, "stack byte counter past access size")
    `EIE_ASSERT_IMPLY(a_div_done_state, div_done, state_reg == S_DIV, "divider finished outside a divide")
    `EIE_ASSERT_IMPLY(a_clear_no_pop, state_reg == S_CLEAR, !pop && hold, "instruction taken during stack clearing")

endmodule
